/* sv/ntts_pkg.sv */
package ntts_pkg;

	// operation codes on func
	localparam logic [2:0] FUNC_ADD_INTERVAL = 3'd0;
	localparam logic [2:0] FUNC_ADD_TIMEOUT  = 3'd1;
	localparam logic [2:0] FUNC_ADD_DEFER    = 3'd2;
	localparam logic [2:0] FUNC_CANCEL_INT   = 3'd3;
	localparam logic [2:0] FUNC_CANCEL_TMO   = 3'd4;
	localparam logic [2:0] FUNC_CANCEL_DEF   = 3'd5;
	localparam logic [2:0] FUNC_POLL         = 3'd6;
	localparam logic [2:0] FUNC_UNUSED       = 3'd7;

	// entry types
	localparam logic [1:0] TYPE_INTERVAL = 2'd0;
	localparam logic [1:0] TYPE_TIMEOUT  = 2'd1;
	localparam logic [1:0] TYPE_DEFER    = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_FIRE   = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_ZERO_INT  = 2'd3;

	// table write kinds
	localparam logic [1:0] WR_MARK = 2'd0;
	localparam logic [1:0] WR_NEW  = 2'd1;
	localparam logic [1:0] WR_LAST = 2'd2;
	localparam logic [1:0] WR_COPY = 2'd3;

	// write address select
	localparam logic [1:0] WA_I     = 2'd0;
	localparam logic [1:0] WA_COUNT = 2'd1;
	localparam logic [1:0] WA_W     = 2'd2;

	// divider dividend select
	localparam logic DIV_RANDOM = 1'b0;
	localparam logic DIV_ELAPSED = 1'b1;

	typedef struct packed {
		logic [7:0]  key;
		logic [1:0]  etype;
		logic [31:0] period;
		logic [31:0] last_run;
		logic        removed;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic       load_in;
		logic       i_clr;
		logic       i_inc;
		logic       w_clr;
		logic       w_inc;
		logic       cnt_inc;
		logic       cnt_from_w;
		logic       ent_load;
		logic       wr_en;
		logic [1:0] wr_kind;
		logic [1:0] wr_addr_sel;
		logic       div_start;
		logic       div_sel;
		logic       emit;
		logic [1:0] emit_kind;
		logic [1:0] emit_status;
		logic       emit_last;
	} ntts_cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic [1:0] op_type;
		logic       key_zero;
		logic       period_zero;
		logic       full;
		logic       i_end;
		logic       match;
		logic       due;
		logic [1:0] ent_type;
		logic       ent_removed;
		logic       ent_period_zero;
		logic       w_eq_i;
		logic       div_busy;
		logic       out_free;
	} ntts_sts_t;

endpackage

/* sv/ntts_ram.sv */
module ntts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/ntts_dp.sv */
module ntts_dp #(
	parameter int SLOTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [2:0]        func,
	input  logic [7:0]        name_key,
	input  logic [31:0]       period,
	input  logic [31:0]       now,
	input  logic [31:0]       random_word,
	input  ntts_pkg::ntts_cmd_t cmd,
	output ntts_pkg::ntts_sts_t sts,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        kind,
	output logic [7:0]        fired_key,
	output logic [1:0]        fired_type,
	output logic [1:0]        status,
	output logic              last
);
	import ntts_pkg::*;

	localparam int AW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	// latched item
	logic [2:0]  func_q;
	logic [7:0]  key_q;
	logic [31:0] period_q, now_q, rnd_q;

	// table walk counters
	logic [CW-1:0] i_q, w_q, count_q;

	entry_t ent_q, rd_ent, wr_ent;
	logic [ENTRY_W-1:0] rdata;
	logic [AW-1:0] waddr;
	logic [1:0] op_type;
	logic [31:0] elapsed;

	// divider
	logic        div_busy_q;
	logic [5:0]  div_cnt_q;
	logic [31:0] div_rem_q, div_num_q, div_den_q;
	logic [32:0] div_trial;

	logic out_free;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q   <= func;
			key_q    <= name_key;
			period_q <= period;
			now_q    <= now;
			rnd_q    <= random_word;
		end
		if (cmd.ent_load) begin
			ent_q <= rd_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q     <= '0;
			w_q     <= '0;
			count_q <= '0;
		end else begin
			if (cmd.i_clr) begin
				i_q <= '0;
			end else if (cmd.i_inc) begin
				i_q <= i_q + CW'(1);
			end
			if (cmd.w_clr) begin
				w_q <= '0;
			end else if (cmd.w_inc) begin
				w_q <= w_q + CW'(1);
			end
			if (cmd.cnt_from_w) begin
				count_q <= w_q;
			end else if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	assign op_type = (func_q <= FUNC_ADD_DEFER) ? func_q[1:0] : 2'(func_q - FUNC_CANCEL_INT);
	assign elapsed = now_q - ent_q.last_run;
	assign rd_ent  = entry_t'(rdata);

	// remainder only: restoring division, one quotient bit per cycle
	assign div_trial = {div_rem_q, div_num_q[31]} - {1'b0, div_den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
		end else if (cmd.div_start) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= 6'd32;
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q - 6'd1;
			if (div_cnt_q == 6'd1) begin
				div_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_rem_q <= '0;
			if (cmd.div_sel == DIV_ELAPSED) begin
				div_num_q <= elapsed;
				div_den_q <= ent_q.period;
			end else begin
				div_num_q <= rnd_q;
				div_den_q <= period_q;
			end
		end else if (div_busy_q) begin
			div_num_q <= {div_num_q[30:0], 1'b0};
			if (!div_trial[32]) begin
				div_rem_q <= div_trial[31:0];
			end else begin
				div_rem_q <= {div_rem_q[30:0], div_num_q[31]};
			end
		end
	end

	// table write data
	always_comb begin
		wr_ent = ent_q;
		case (cmd.wr_kind)
			WR_MARK: wr_ent.removed = 1'b1;
			WR_NEW: begin
				wr_ent.key     = key_q;
				wr_ent.etype   = op_type;
				wr_ent.removed = 1'b0;
				case (op_type)
					TYPE_INTERVAL: begin
						wr_ent.period   = period_q;
						wr_ent.last_run = now_q - period_q - {1'b0, div_rem_q[31:1]};
					end
					TYPE_TIMEOUT: begin
						wr_ent.period   = period_q;
						wr_ent.last_run = now_q;
					end
					default: begin
						wr_ent.period   = '0;
						wr_ent.last_run = '0;
					end
				endcase
			end
			WR_LAST: wr_ent.last_run = now_q - div_rem_q;
			default: wr_ent.removed = 1'b0;
		endcase
	end

	always_comb begin
		case (cmd.wr_addr_sel)
			WA_COUNT: waddr = count_q[AW-1:0];
			WA_W:     waddr = w_q[AW-1:0];
			default:  waddr = i_q[AW-1:0];
		endcase
	end

	ntts_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_table (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(waddr),
		.wdata(wr_ent),
		.raddr(i_q[AW-1:0]),
		.rdata(rdata)
	);

	// result register
	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind   <= cmd.emit_kind;
			status <= cmd.emit_status;
			last   <= cmd.emit_last;
			case (cmd.emit_kind)
				KIND_FIRE: begin
					fired_key  <= ent_q.key;
					fired_type <= ent_q.etype;
				end
				KIND_DONE: begin
					fired_key  <= '0;
					fired_type <= '0;
				end
				default: begin
					fired_key  <= key_q;
					fired_type <= op_type;
				end
			endcase
		end
	end

	// status to the controller
	always_comb begin
		sts.func            = func_q;
		sts.op_type         = op_type;
		sts.key_zero        = (key_q == 8'd0);
		sts.period_zero     = (period_q == 32'd0);
		sts.full            = (count_q == CW'(SLOTS));
		sts.i_end           = (i_q == count_q);
		sts.match           = !ent_q.removed && (ent_q.key == key_q) && (ent_q.etype == op_type);
		sts.due             = !ent_q.removed &&
			((ent_q.etype == TYPE_DEFER) || (elapsed > ent_q.period));
		sts.ent_type        = ent_q.etype;
		sts.ent_removed     = ent_q.removed;
		sts.ent_period_zero = (ent_q.period == 32'd0);
		sts.w_eq_i          = (w_q == i_q);
		sts.div_busy        = div_busy_q;
		sts.out_free        = out_free;
	end

endmodule

/* sv/ntts_ctrl.sv */
module ntts_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ntts_pkg::ntts_sts_t sts,
	output ntts_pkg::ntts_cmd_t cmd
);
	import ntts_pkg::*;

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_DECODE   = 5'd1;
	localparam logic [4:0] S_SCAN_RD  = 5'd2;
	localparam logic [4:0] S_SCAN_LD  = 5'd3;
	localparam logic [4:0] S_SCAN_EV  = 5'd4;
	localparam logic [4:0] S_ADD_GO   = 5'd5;
	localparam logic [4:0] S_ADD_DIV  = 5'd6;
	localparam logic [4:0] S_ADD_WR   = 5'd7;
	localparam logic [4:0] S_EMIT     = 5'd8;
	localparam logic [4:0] S_POLL_RD  = 5'd9;
	localparam logic [4:0] S_POLL_LD  = 5'd10;
	localparam logic [4:0] S_POLL_EV  = 5'd11;
	localparam logic [4:0] S_POLL_DIV = 5'd12;
	localparam logic [4:0] S_COMP_RD  = 5'd13;
	localparam logic [4:0] S_COMP_LD  = 5'd14;
	localparam logic [4:0] S_COMP_EV  = 5'd15;
	localparam logic [4:0] S_POLL_END = 5'd16;

	logic [4:0] state_q, state_d;
	logic [1:0] stat_q, stat_d;
	logic is_add;

	assign is_add   = (sts.func <= FUNC_ADD_DEFER);
	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stat_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			stat_q  <= stat_d;
		end
	end

	always_comb begin
		state_d = state_q;
		stat_d  = stat_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					cmd.i_clr   = 1'b1;
					cmd.w_clr   = 1'b1;
					state_d     = S_DECODE;
				end
			end
			// sort out errors and pick the walk
			S_DECODE: begin
				if (is_add) begin
					if (sts.op_type == TYPE_INTERVAL && sts.period_zero) begin
						stat_d  = ST_ZERO_INT;
						state_d = S_EMIT;
					end else if (sts.full) begin
						stat_d  = ST_FULL;
						state_d = S_EMIT;
					end else if (sts.key_zero) begin
						state_d = S_ADD_GO;
					end else begin
						state_d = S_SCAN_RD;
					end
				end else if (sts.func == FUNC_POLL) begin
					state_d = S_POLL_RD;
				end else if (sts.func == FUNC_CANCEL_INT || sts.func == FUNC_CANCEL_TMO ||
						sts.func == FUNC_CANCEL_DEF) begin
					if (sts.key_zero) begin
						stat_d  = ST_NOT_FOUND;
						state_d = S_EMIT;
					end else begin
						state_d = S_SCAN_RD;
					end
				end else begin
					state_d = S_IDLE;
				end
			end
			// look for the first live entry of this key and type
			S_SCAN_RD: begin
				if (sts.i_end) begin
					stat_d  = ST_NOT_FOUND;
					state_d = is_add ? S_ADD_GO : S_EMIT;
				end else begin
					state_d = S_SCAN_LD;
				end
			end
			S_SCAN_LD: begin
				cmd.ent_load = 1'b1;
				state_d      = S_SCAN_EV;
			end
			S_SCAN_EV: begin
				if (sts.match) begin
					cmd.wr_en       = 1'b1;
					cmd.wr_kind     = WR_MARK;
					cmd.wr_addr_sel = WA_I;
					stat_d          = ST_OK;
					state_d         = is_add ? S_ADD_GO : S_EMIT;
				end else begin
					cmd.i_inc = 1'b1;
					state_d   = S_SCAN_RD;
				end
			end
			S_ADD_GO: begin
				if (sts.op_type == TYPE_INTERVAL) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_RANDOM;
					state_d       = S_ADD_DIV;
				end else begin
					state_d = S_ADD_WR;
				end
			end
			S_ADD_DIV: begin
				if (!sts.div_busy) begin
					state_d = S_ADD_WR;
				end
			end
			S_ADD_WR: begin
				cmd.wr_en       = 1'b1;
				cmd.wr_kind     = WR_NEW;
				cmd.wr_addr_sel = WA_COUNT;
				cmd.cnt_inc     = 1'b1;
				stat_d          = ST_OK;
				state_d         = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_kind   = KIND_STATUS;
					cmd.emit_status = stat_q;
					cmd.emit_last   = 1'b1;
					state_d         = S_IDLE;
				end
			end
			// poll: fire pass
			S_POLL_RD: begin
				if (sts.i_end) begin
					cmd.i_clr = 1'b1;
					state_d   = S_COMP_RD;
				end else begin
					state_d = S_POLL_LD;
				end
			end
			S_POLL_LD: begin
				cmd.ent_load = 1'b1;
				state_d      = S_POLL_EV;
			end
			S_POLL_EV: begin
				if (!sts.due) begin
					cmd.i_inc = 1'b1;
					state_d   = S_POLL_RD;
				end else if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_FIRE;
					if (sts.ent_type != TYPE_INTERVAL) begin
						cmd.wr_en       = 1'b1;
						cmd.wr_kind     = WR_MARK;
						cmd.wr_addr_sel = WA_I;
						cmd.i_inc       = 1'b1;
						state_d         = S_POLL_RD;
					end else if (sts.ent_period_zero) begin
						cmd.i_inc = 1'b1;
						state_d   = S_POLL_RD;
					end else begin
						cmd.div_start = 1'b1;
						cmd.div_sel   = DIV_ELAPSED;
						state_d       = S_POLL_DIV;
					end
				end
			end
			// catch up: new last run is now minus the leftover of the elapsed time
			S_POLL_DIV: begin
				if (!sts.div_busy) begin
					cmd.wr_en       = 1'b1;
					cmd.wr_kind     = WR_LAST;
					cmd.wr_addr_sel = WA_I;
					cmd.i_inc       = 1'b1;
					state_d         = S_POLL_RD;
				end
			end
			// poll: compaction pass
			S_COMP_RD: begin
				if (sts.i_end) begin
					cmd.cnt_from_w = 1'b1;
					state_d        = S_POLL_END;
				end else begin
					state_d = S_COMP_LD;
				end
			end
			S_COMP_LD: begin
				cmd.ent_load = 1'b1;
				state_d      = S_COMP_EV;
			end
			S_COMP_EV: begin
				cmd.i_inc = 1'b1;
				if (!sts.ent_removed) begin
					cmd.w_inc = 1'b1;
					if (!sts.w_eq_i) begin
						cmd.wr_en       = 1'b1;
						cmd.wr_kind     = WR_COPY;
						cmd.wr_addr_sel = WA_W;
					end
				end
				state_d = S_COMP_RD;
			end
			S_POLL_END: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_DONE;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* sv/named_timer_table_scheduler_top.sv */
// Named timer table scheduler.
// Input channel (in_valid/in_ready) carries one operation item: add an
// interval, timeout or defer entry, cancel one, or poll with the current time.
// Output channel (out_valid/out_ready) carries result items; the final result
// of each operation has last set. Add and cancel give one status result, a
// poll gives one fire result per due entry and then a poll-finished result.
// One item is processed at a time; in_ready is high only while idle.
// An add or cancel with a nonzero key walks the table entry by entry (read,
// load, evaluate); an interval add then divides the random word by the period
// for its start offset. A poll walks the table to fire due entries, running
// the remainder unit per fired interval with a nonzero period, then compacts.
// Table state sits in a single-port-write RAM read one entry a cycle.
// Results go through one output register: while it is held by a stalled
// receiver the walk pauses at the next result, and a new item can still be
// taken once the previous one has issued its last result.
// Reset empties the table (entry count zero) and clears the output valid flag.
module named_timer_table_scheduler_top #(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [7:0]  name_key,
	input  logic [31:0] period,
	input  logic [31:0] now,
	input  logic [31:0] random_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  fired_key,
	output logic [1:0]  fired_type,
	output logic [1:0]  status,
	output logic        last
);
	import ntts_pkg::*;

	ntts_cmd_t cmd;
	ntts_sts_t sts;

	ntts_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	ntts_dp #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.func       (func),
		.name_key   (name_key),
		.period     (period),
		.now        (now),
		.random_word(random_word),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.fired_key  (fired_key),
		.fired_type (fired_type),
		.status     (status),
		.last       (last)
	);

endmodule

/* sv/ntts_checker.sv */
module ntts_props (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic [7:0] fired_key,
	input logic [1:0] fired_type,
	input logic [1:0] status,
	input logic       last
);
	import ntts_pkg::*;

	// stalled result stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(kind) && $stable(fired_key) && $stable(status))
		else $error("result changed while stalled");

	// poll finished always closes the item
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_DONE |-> last && fired_key == 8'd0)
		else $error("poll finished not last or keyed");

	// a fire is never the last result and carries no status
	a_fire: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_FIRE |-> !last && status == ST_OK)
		else $error("bad fire result");

	// status results are last and carry a valid entry type
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_STATUS |-> last && fired_type != 2'd3)
		else $error("bad status result");

endmodule

bind named_timer_table_scheduler_top ntts_props u_ntts_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.kind      (kind),
	.fired_key (fired_key),
	.fired_type(fired_type),
	.status    (status),
	.last      (last)
);
